/* rtl/core/bhpq_pkg.sv */
// Shared types, constants and helpers for the binary heap priority queue.
`timescale 1ns / 1ps

package bhpq_pkg;

   // Default heap depth
   localparam int BHPQ_CAPACITY = 256;

   // Fixed field widths
   localparam int PRICE_W = 32;
   localparam int COUNT_OUT_W = 9;
   localparam int REQ_W = 2;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH = 2'd0,
      REQ_POP  = 2'd1,
      REQ_PEEK = 2'd2
   } req_code_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_CHK,
      S_UP_CMP,
      S_POP_RD,
      S_POP_LD,
      S_DN_CHK,
      S_DN_RL,
      S_DN_CMP,
      S_ROOT_RD,
      S_DONE
   } state_type;

   // Memory read address select
   typedef enum logic [2:0] {
      RD_NONE,
      RD_PARENT,
      RD_TAIL,
      RD_LEFT,
      RD_RIGHT,
      RD_ROOT
   } rd_sel_type;

   // Memory write select
   typedef enum logic [1:0] {
      WR_NONE,
      WR_VAL,
      WR_PARENT,
      WR_CHILD
   } wr_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       drop_set;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       idx_tail;
      logic       idx_clear;
      logic       val_price;
      logic       val_rd;
      logic       lval_load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      req_code_type req;
      logic         full;
      logic         empty;
      logic         at_root;
      logic         has_left;
      logic         has_right;
      logic         up_move;
      logic         dn_move;
   } sts_type;

   // True when x belongs closer to the root than y under the given order
   function automatic logic ranks_before(input logic order,
                                         input logic [PRICE_W-1:0] x,
                                         input logic [PRICE_W-1:0] y);
      ranks_before = order ? (x > y) : (x < y);
   endfunction

endpackage

/* rtl/core/binary_heap_priority_queue.sv */
// Top level of the binary heap priority queue: controller plus datapath.
`timescale 1ns / 1ps

// Binary heap of 32-bit prices, min-heap (csr_heap_order 0) or max-heap (1).
// A request is taken when start is high and busy is low; every request
// returns one result beat on rsp_valid, which lasts a single cycle and
// cannot be stalled, so the receiver must take it when it appears. busy
// stays high from acceptance through the result beat. At 256 entries a
// pushed value can climb up to 8 levels and a popped entry can descend up
// to 7. The entry memory has a single read port, so each level of a sift
// needs its own registered read (one for the parent, up to two for the
// children). The user must write csr_heap_order only while busy is low;
// the block itself does not enforce it, since csr_ready is always high.
// A write to csr_heap_order does not reorder stored entries.

module binary_heap_priority_queue import bhpq_pkg::*; #(
   parameter int CAPACITY = BHPQ_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [REQ_W-1:0]       req_type,
   input  logic [PRICE_W-1:0]     req_price,
   output logic                   rsp_valid,
   output logic [PRICE_W-1:0]     rsp_top_value,
   output logic                   rsp_is_empty,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                   rsp_dropped,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_heap_order
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   bhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Heap storage and arithmetic
   bhpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_price       (req_price),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_heap_order  (csr_heap_order),
      .rsp_top_value   (rsp_top_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .rsp_dropped     (rsp_dropped)
   );

endmodule

/* rtl/core/bhpq_dp.sv */
// Datapath of the heap: entry memory, count, sift index and value registers.
`timescale 1ns / 1ps

module bhpq_dp import bhpq_pkg::*; #(
   parameter int CAPACITY = BHPQ_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [REQ_W-1:0]       req_type,
   input  logic [PRICE_W-1:0]     req_price,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_heap_order,
   output logic [PRICE_W-1:0]     rsp_top_value,
   output logic                   rsp_is_empty,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic                   rsp_dropped
);

   localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + 1;

   logic [PRICE_W-1:0] mem [CAPACITY];

   logic                order_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                drop_ff, drop_in;
   req_code_type        req_ff, req_in;
   logic [PRICE_W-1:0]  val_ff, val_in;
   logic [PRICE_W-1:0]  lval_ff, lval_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [PRICE_W-1:0]  rd_data_ff;

   logic [XW-1:0]       left_x, right_x;
   logic [AW-1:0]       parent_idx, child_idx;
   logic                pick_right;
   logic [PRICE_W-1:0]  child_val;
   logic                rd_en, wr_en;
   logic [AW-1:0]       rd_addr;
   logic [PRICE_W-1:0]  wr_data;
   logic [CW+COUNT_OUT_W-1:0] cnt_ext;

   // Tree neighbors of the sift index
   assign left_x     = (XW'(idx_ff) << 1) | XW'(1);
   assign right_x    = left_x + XW'(1);
   assign parent_idx = AW'((idx_ff - AW'(1)) >> 1);

   // Pick the better child, left on a tie
   assign pick_right = sts.has_right && ranks_before(order_ff, rd_data_ff, lval_ff);
   assign child_val  = pick_right ? rd_data_ff : lval_ff;
   assign child_idx  = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];

   // Status toward the controller
   always_comb begin
      sts.req       = req_ff;
      sts.full      = (cnt_ff >= CW'(CAPACITY));
      sts.empty     = (cnt_ff == '0);
      sts.at_root   = (idx_ff == '0);
      sts.has_left  = (left_x < XW'(cnt_ff));
      sts.has_right = (right_x < XW'(cnt_ff));
      sts.up_move   = ranks_before(order_ff, val_ff, rd_data_ff);
      sts.dn_move   = ranks_before(order_ff, child_val, val_ff);
   end

   // Memory address and data select
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      case (cmd.rd_sel)
         RD_NONE:   rd_en = 1'b0;
         RD_PARENT: rd_addr = parent_idx;
         RD_TAIL:   rd_addr = cnt_ff[AW-1:0];
         RD_LEFT:   rd_addr = left_x[AW-1:0];
         RD_RIGHT:  rd_addr = right_x[AW-1:0];
         RD_ROOT:   rd_addr = '0;
         default:   rd_en = 1'b0;
      endcase

      wr_en   = 1'b1;
      wr_data = val_ff;
      case (cmd.wr_sel)
         WR_NONE:   wr_en = 1'b0;
         WR_VAL:    wr_data = val_ff;
         WR_PARENT: wr_data = rd_data_ff;
         WR_CHILD:  wr_data = child_val;
         default:   wr_en = 1'b0;
      endcase
   end

   // Entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next values of the working registers
   always_comb begin
      cnt_in  = cnt_ff;
      drop_in = drop_ff;
      req_in  = req_ff;
      val_in  = val_ff;
      lval_in = lval_ff;
      idx_in  = idx_ff;

      if (cmd.load_req) begin
         req_in  = req_code_type'(req_type);
         drop_in = 1'b0;
      end
      if (cmd.drop_set) begin
         drop_in = 1'b1;
      end
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.val_price) begin
         val_in = req_price;
      end else if (cmd.val_rd) begin
         val_in = rd_data_ff;
      end
      if (cmd.lval_load) begin
         lval_in = rd_data_ff;
      end

      if (cmd.idx_tail) begin
         idx_in = cnt_ff[AW-1:0];
      end else if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.wr_sel == WR_PARENT) begin
         idx_in = parent_idx;
      end else if (cmd.wr_sel == WR_CHILD) begin
         idx_in = child_idx;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            order_ff <= csr_heap_order;
         end
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      val_ff  <= val_in;
      lval_ff <= lval_in;
      idx_ff  <= idx_in;
   end

   assign csr_ready = 1'b1;

   // Result fields; root read lands in rd_data_ff just before the strobe
   assign cnt_ext         = (CW + COUNT_OUT_W)'(cnt_ff);
   assign rsp_top_value   = sts.empty ? '0 : rd_data_ff;
   assign rsp_is_empty    = sts.empty;
   assign rsp_entry_count = cnt_ext[COUNT_OUT_W-1:0];
   assign rsp_dropped     = drop_ff;

`ifndef ASSERT_OFF
   // Count never passes the capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // Writes land only inside the occupied region
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (XW'(idx_ff) < XW'(cnt_ff)))
      else $error("heap write outside occupied entries");

   // A count increment never wraps to zero
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |=> (cnt_ff == $past(cnt_ff) + CW'(1)) && (cnt_ff != '0))
      else $error("count increment wrapped");
`endif

endmodule

/* rtl/core/bhpq_ctrl.sv */
// Controller state machine sequencing push, pop and peek over the heap datapath.
`timescale 1ns / 1ps

module bhpq_ctrl import bhpq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = RD_NONE;
      cmd.wr_sel    = WR_NONE;
      busy          = 1'b1;
      rsp_valid     = 1'b0;

      case (state_ff)
         // Capture the request beat, price included
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_req  = 1'b1;
               cmd.val_price = 1'b1;
               state_in      = S_DISPATCH;
            end
         end

         // Decode the latched request
         S_DISPATCH: begin
            case (sts.req)
               REQ_PUSH: begin
                  if (sts.full) begin
                     cmd.drop_set = 1'b1;
                     state_in     = S_ROOT_RD;
                  end else begin
                     cmd.idx_tail  = 1'b1;
                     cmd.cnt_inc   = 1'b1;
                     state_in      = S_UP_CHK;
                  end
               end
               REQ_POP: begin
                  if (sts.empty) begin
                     cmd.drop_set = 1'b1;
                     state_in     = S_ROOT_RD;
                  end else begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_POP_RD;
                  end
               end
               default: state_in = S_ROOT_RD;
            endcase
         end

         // Sift up: fetch parent or settle at the root
         S_UP_CHK: begin
            if (sts.at_root) begin
               cmd.wr_sel = WR_VAL;
               state_in   = S_ROOT_RD;
            end else begin
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end

         // Sift up: move parent down or drop the value in place
         S_UP_CMP: begin
            if (sts.up_move) begin
               cmd.wr_sel = WR_PARENT;
               state_in   = S_UP_CHK;
            end else begin
               cmd.wr_sel = WR_VAL;
               state_in   = S_ROOT_RD;
            end
         end

         // Pop: fetch the tail entry unless the heap just went empty
         S_POP_RD: begin
            cmd.idx_clear = 1'b1;
            if (sts.empty) begin
               state_in = S_ROOT_RD;
            end else begin
               cmd.rd_sel = RD_TAIL;
               state_in   = S_POP_LD;
            end
         end

         S_POP_LD: begin
            cmd.val_rd = 1'b1;
            state_in   = S_DN_CHK;
         end

         // Sift down: fetch left child or settle at a leaf
         S_DN_CHK: begin
            if (sts.has_left) begin
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_RL;
            end else begin
               cmd.wr_sel = WR_VAL;
               state_in   = S_ROOT_RD;
            end
         end

         // Sift down: hold left child, fetch right child
         S_DN_RL: begin
            cmd.lval_load = 1'b1;
            if (sts.has_right) begin
               cmd.rd_sel = RD_RIGHT;
            end
            state_in = S_DN_CMP;
         end

         // Sift down: move the better child up or drop the value in place
         S_DN_CMP: begin
            if (sts.dn_move) begin
               cmd.wr_sel = WR_CHILD;
               state_in   = S_DN_CHK;
            end else begin
               cmd.wr_sel = WR_VAL;
               state_in   = S_ROOT_RD;
            end
         end

         S_ROOT_RD: begin
            cmd.rd_sel = RD_ROOT;
            state_in   = S_DONE;
         end

         // Present the result beat
         S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   // An accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // The result beat ends the request
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block still busy after result beat");

   // Busy falls only right after a result beat
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("request finished without a result beat");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the binary heap priority queue top level.
`timescale 1ns / 1ps

module testbench;
   import bhpq_pkg::*;

   // Unused request code; the block treats it as a peek
   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
   // Idle cycles with no handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   // One result beat as seen on the rsp_ ports
   typedef struct packed {
      logic [PRICE_W-1:0]     top;
      logic                   empty;
      logic [COUNT_OUT_W-1:0] count;
      logic                   dropped;
   } heap_beat_type;

   // Shadow heap plus the queue of result beats still owed by the block
   class heap_tracker;
      logic [PRICE_W-1:0] entries [BHPQ_CAPACITY];
      int unsigned        fill;
      logic               max_order;
      heap_beat_type      pending_beats[$];
      int                 mismatches;
      int                 beats_checked;
      int                 n_push, n_pop, n_peek, n_drop, peak_fill;

      function new();
         fill = 0;
         max_order = 1'b0;
         mismatches = 0;
         beats_checked = 0;
         n_push = 0;
         n_pop = 0;
         n_peek = 0;
         n_drop = 0;
         peak_fill = 0;
      endfunction

      function void set_order(logic order);
         max_order = order;
      endfunction

      // Strict compare: equal values never move
      function logic goes_higher(logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
         return max_order ? (a > b) : (a < b);
      endfunction

      function void swap_entries(int unsigned i, int unsigned j);
         logic [PRICE_W-1:0] t;
         t = entries[i];
         entries[i] = entries[j];
         entries[j] = t;
      endfunction

      // Apply one accepted request to the shadow heap and queue its result
      function void note_request(logic [REQ_W-1:0] kind, logic [PRICE_W-1:0] price);
         heap_beat_type beat;
         int unsigned   i, up, l, r, best;
         logic          drop;
         drop = 1'b0;
         if (kind == REQ_PUSH) begin
            n_push++;
            if (fill >= BHPQ_CAPACITY) begin
               drop = 1'b1;
            end else begin
               i = fill;
               entries[i] = price;
               fill++;
               // Sift up while the new value outranks its parent
               while (i > 0) begin
                  up = (i - 1) / 2;
                  if (!goes_higher(entries[i], entries[up])) break;
                  swap_entries(i, up);
                  i = up;
               end
            end
         end else if (kind == REQ_POP) begin
            n_pop++;
            if (fill == 0) begin
               drop = 1'b1;
            end else begin
               fill--;
               entries[0] = entries[fill];
               i = 0;
               // Sift down; on a child tie the left child wins
               forever begin
                  l = 2 * i + 1;
                  r = 2 * i + 2;
                  best = i;
                  if (l < fill && goes_higher(entries[l], entries[best])) best = l;
                  if (r < fill && goes_higher(entries[r], entries[best])) best = r;
                  if (best == i) break;
                  swap_entries(i, best);
                  i = best;
               end
            end
         end else begin
            n_peek++;
         end
         if (drop) n_drop++;
         if (fill > peak_fill) peak_fill = fill;
         beat.top = (fill == 0) ? '0 : entries[0];
         beat.empty = (fill == 0);
         beat.count = fill[COUNT_OUT_W-1:0];
         beat.dropped = drop;
         pending_beats.push_back(beat);
      endfunction

      // Compare one result beat with the oldest owed beat
      function void check_response(heap_beat_type got);
         heap_beat_type want;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat top=%h empty=%b count=%0d dropped=%b",
                        $realtime, got.top, got.empty, got.count, got.dropped);
            return;
         end
         want = pending_beats.pop_front();
         beats_checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch expected top=%h empty=%b count=%0d dropped=%b,",
                        $realtime, want.top, want.empty, want.count, want.dropped);
               $display("   got top=%h empty=%b count=%0d dropped=%b",
                        got.top, got.empty, got.count, got.dropped);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [REQ_W-1:0]   req_type;
   logic [PRICE_W-1:0] req_price;
   logic               rsp_valid;
   logic [PRICE_W-1:0] rsp_top_value;
   logic               rsp_is_empty;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic               rsp_dropped;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_heap_order;

   heap_tracker heap_model;
   int          burst_left;
   int          idle_cycles;
   int          order_writes;

   binary_heap_priority_queue u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_price       (req_price),
      .rsp_valid       (rsp_valid),
      .rsp_top_value   (rsp_top_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .rsp_dropped     (rsp_dropped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_heap_order  (csr_heap_order)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every result beat against the shadow heap
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         heap_model.check_response({rsp_top_value, rsp_is_empty, rsp_entry_count, rsp_dropped});
   end

   // End the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Pick a price: mostly full-range, some extremes and a narrow band for ties
   function automatic logic [PRICE_W-1:0] next_price();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      if (sel < 4) return PRICE_W'($urandom_range(0, 15));
      return PRICE_W'($urandom);
   endfunction

   // Drive one request beat, wait for acceptance, then idle at random
   task automatic issue(input logic [REQ_W-1:0] kind, input logic [PRICE_W-1:0] price);
      int gap;
      int sel;
      start = 1'b1;
      req_type = kind;
      req_price = price;
      @(posedge clock);
      while (busy) @(posedge clock);
      heap_model.note_request(kind, price);
      @(negedge clock);
      // Hold start through bursts, otherwise insert a mostly short gap
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            burst_left = $urandom_range(15, 50);
            gap = 0;
         end else if (sel < 55) begin
            gap = $urandom_range(0, 2);
         end else if (sel < 93) begin
            gap = $urandom_range(3, 6);
         end else begin
            gap = $urandom_range(10, 40);
         end
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Wait for every owed beat, then write the order register
   task automatic write_heap_order(input logic order);
      start = 1'b0;
      while (heap_model.pending_beats.size() != 0) @(negedge clock);
      repeat ($urandom_range(0, 3)) @(negedge clock);
      csr_valid = 1'b1;
      csr_heap_order = order;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      heap_model.set_order(order);
      order_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random mix of request codes with the given percentages
   task automatic run_mix(input int items, input int push_pct, input int pop_pct,
                          input int peek_pct);
      int sel;
      logic [REQ_W-1:0] kind;
      for (int n = 0; n < items; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < push_pct) kind = REQ_PUSH;
         else if (sel < push_pct + pop_pct) kind = REQ_POP;
         else if (sel < push_pct + pop_pct + peek_pct) kind = REQ_PEEK;
         else kind = REQ_SPARE;
         issue(kind, next_price());
      end
      start = 1'b0;
   endtask

   initial begin
      heap_model = new();
      burst_left = 0;
      order_writes = 0;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_PUSH;
      req_price = '0;
      csr_valid = 1'b0;
      csr_heap_order = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty-heap cases, extremes, ties, spare code, drain past empty
      write_heap_order(1'b0);
      issue(REQ_PEEK, '1);
      issue(REQ_POP, '0);
      issue(REQ_SPARE, 32'h5A5A_A5A5);
      issue(REQ_PUSH, 32'hFFFF_FFFF);
      issue(REQ_PUSH, 32'h0000_0000);
      issue(REQ_PUSH, 32'h0000_0000);
      issue(REQ_PUSH, 32'd5);
      issue(REQ_PUSH, 32'd5);
      issue(REQ_PUSH, 32'h8000_0000);
      issue(REQ_SPARE, '0);
      repeat (3) issue(REQ_POP, '0);
      issue(REQ_PUSH, 32'd7);
      issue(REQ_PUSH, 32'd7);
      issue(REQ_PUSH, 32'd3);
      repeat (7) issue(REQ_POP, '1);
      start = 1'b0;

      // Max-heap from empty with a balanced mix
      write_heap_order(1'b1);
      run_mix(150, 45, 35, 15);
      // Min-heap over leftover max-ordered entries, fill past full
      write_heap_order(1'b0);
      run_mix(320, 92, 4, 2);
      // Max-heap over a full min-ordered heap, drain past empty
      write_heap_order(1'b1);
      run_mix(320, 4, 92, 2);
      write_heap_order(1'b0);
      run_mix(40, 45, 35, 15);

      // Drain owed beats and let the block settle
      while (heap_model.pending_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d pushes, %0d pops, %0d peeks, %0d dropped, peak fill %0d of %0d",
               heap_model.n_push, heap_model.n_pop, heap_model.n_peek,
               heap_model.n_drop, heap_model.peak_fill, BHPQ_CAPACITY);
      $display("Checked %0d result beats over %0d order writes, %0d mismatches",
               heap_model.beats_checked, order_writes, heap_model.mismatches);
      if (heap_model.mismatches == 0 && heap_model.pending_beats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
